>>> rtl/aopt_pkg.sv
// ----------------------------------------------------------------------------
// aopt_pkg: shared types and constants of the arc odometry pose tracker
// Request structs, config struct, command and status bundles, fixed-point
// constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package aopt_pkg;

  // input request
  typedef struct packed {
    logic               action;
    logic signed [31:0] imu_rotation;
    logic signed [31:0] parallel_travel;
    logic signed [31:0] perpendicular_travel;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_theta;
    logic               theta_is_radians;
  } in_req_t;

  // result request
  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
  } out_req_t;

  typedef struct packed {
    logic               use_drive_encoders;
    logic signed [31:0] par_wheel_offset;
    logic signed [31:0] perp_wheel_offset;
    logic        [30:0] half_track_width;
    logic        [30:0] travel_scale;
  } cfg_t;

  localparam logic [2:0] CFG_USE_ENC   = 3'd0;
  localparam logic [2:0] CFG_PAR_OFF   = 3'd1;
  localparam logic [2:0] CFG_PERP_OFF  = 3'd2;
  localparam logic [2:0] CFG_HALF_TRK  = 3'd3;
  localparam logic [2:0] CFG_SCALE     = 3'd4;

  localparam logic [30:0] SCALE_RESET = 31'd65536;

  // fixed-point constants, angles in Q4.28
  localparam logic signed [32:0] DEG2RAD_K   = 33'sd74961321;
  localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q28    = 34'sd163008219;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DEG_MUL,
    OP_SET_POSE,
    OP_ENC_MUL,
    OP_DIFF,
    OP_COPY_LOCAL,
    OP_CORDIC_HALF,
    OP_DIV,
    OP_MQ_LOAD,
    OP_MQ_LO,
    OP_MQ_HI,
    OP_MQ_ACC,
    OP_CORDIC_ROT,
    OP_WRAP,
    OP_HEAD,
    OP_PUBLISH
  } op_e;

  // which scaled product is being formed
  typedef enum logic [2:0] {
    MQ_LX,
    MQ_LY,
    MQ_XS,
    MQ_YC,
    MQ_XC,
    MQ_YS
  } mq_sel_e;

  typedef struct packed {
    op_e     op;
    mq_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic set_pose;
    logic dth_zero;
    logic cordic_done;
    logic div_done;
    logic wrap_ok;
  } stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DEG,
    ST_SETP,
    ST_ENC,
    ST_DIFF,
    ST_ZCHK,
    ST_CH_START,
    ST_CH_WAIT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MQ_LOAD,
    ST_MQ_LO,
    ST_MQ_HI,
    ST_MQ_ACC,
    ST_ROT_START,
    ST_ROT_WAIT,
    ST_WRAP,
    ST_HEAD,
    ST_PUB
  } ctrl_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RED,
    CS_ITER
  } cordic_state_e;

  // arctangent of 2^-i in Q4.28
  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd210828714;
      5'd1:  v = 34'sd124459457;
      5'd2:  v = 34'sd65760959;
      5'd3:  v = 34'sd33381290;
      5'd4:  v = 34'sd16755422;
      5'd5:  v = 34'sd8385879;
      5'd6:  v = 34'sd4193963;
      5'd7:  v = 34'sd2097109;
      5'd8:  v = 34'sd1048571;
      5'd9:  v = 34'sd524287;
      default: begin
        if (i < 5'd29) v = 34'sd1 <<< (5'd28 - i);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/aopt_cordic.sv
// ----------------------------------------------------------------------------
// aopt_cordic: iterative sine and cosine
// Reduces the angle into [-pi/2, pi/2] one step a cycle, then runs one
// rotation-mode CORDIC iteration per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aopt_cordic
  import aopt_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [33:0] angle_i,
  output logic                    done_o,
  output logic signed [33:0]      sin_o,
  output logic signed [33:0]      cos_o
);

  localparam int unsigned CW = $clog2(CORDIC_STEPS);

  cordic_state_e       state_q, state_d;
  logic                done_q, done_d;
  logic [CW-1:0]       i_q, i_d;
  logic signed [33:0]  a_q, a_d;
  logic signed [33:0]  x_q, x_d, y_q, y_d, z_q, z_d;
  logic                flip_q, flip_d;
  logic signed [33:0]  b1, dx, dy, at;

  always_comb begin
    b1 = a_q;
    if (a_q > PI_Q28) b1 = a_q - TWO_PI_Q28;
    else if (a_q < -PI_Q28) b1 = a_q + TWO_PI_Q28;
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    at = atan_entry(5'(i_q));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: if (start_i) state_d = CS_RED;
      CS_RED: begin
        if (!(a_q >= TWO_PI_Q28) && !(a_q <= -TWO_PI_Q28)) state_d = CS_ITER;
      end
      CS_ITER: if (i_q == CW'(CORDIC_STEPS - 1)) state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    done_d = 1'b0;
    i_d    = i_q;
    a_d    = a_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    case (state_q)
      CS_IDLE: if (start_i) a_d = angle_i;
      CS_RED: begin
        if (a_q >= TWO_PI_Q28) a_d = a_q - TWO_PI_Q28;
        else if (a_q <= -TWO_PI_Q28) a_d = a_q + TWO_PI_Q28;
        else begin
          // fold into the right half plane
          x_d = GAIN_Q28;
          y_d = '0;
          i_d = '0;
          if (b1 > HALF_PI_Q28) begin
            z_d = b1 - PI_Q28;
            flip_d = 1'b1;
          end else if (b1 < -HALF_PI_Q28) begin
            z_d = b1 + PI_Q28;
            flip_d = 1'b1;
          end else begin
            z_d = b1;
            flip_d = 1'b0;
          end
        end
      end
      CS_ITER: begin
        if (!z_q[33]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - at;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + at;
        end
        i_d = i_q + 1'b1;
        if (i_q == CW'(CORDIC_STEPS - 1)) done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    a_q    <= a_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign done_o = done_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;

endmodule

`default_nettype wire

>>> rtl/aopt_div.sv
// ----------------------------------------------------------------------------
// aopt_div: serial signed divide of delta * 2^28 by the angle change
// Restoring divide on magnitudes, one quotient bit per cycle, truncated
// toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module aopt_div
  import aopt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] delta_i,
  input  wire logic signed [31:0] divisor_i,
  output logic                    done_o,
  output logic signed [60:0]      quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [59:0] num_q, num_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_n, mag_d;
  logic [32:0] rem_sh, rem_sub;
  logic        qbit;

  always_comb begin
    mag_n   = delta_i[31] ? 32'(-delta_i) : 32'(delta_i);
    mag_d   = divisor_i[31] ? 32'(-divisor_i) : 32'(divisor_i);
    rem_sh  = {rem_q, num_q[59]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    qbit    = (rem_sh >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd59;
      num_d  = {mag_n, 28'b0};
      rem_d  = '0;
      dvs_d  = mag_d;
      neg_d  = delta_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      rem_d = qbit ? rem_sub[31:0] : rem_sh[31:0];
      num_d = {num_q[58:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

`default_nettype wire

>>> rtl/aopt_ctrl.sv
// ----------------------------------------------------------------------------
// aopt_ctrl: sequencer of the pose tracker
// Walks one request through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module aopt_ctrl
  import aopt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  mq_sel_e     sel_q, sel_d;
  logic        out_valid_q, out_valid_d;
  logic        pub_ok;

  assign pub_ok = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_DEG;
      ST_DEG:       state_d = stat_i.set_pose ? ST_SETP : ST_ENC;
      ST_SETP:      state_d = ST_PUB;
      ST_ENC:       state_d = ST_DIFF;
      ST_DIFF:      state_d = ST_ZCHK;
      ST_ZCHK: begin
        if (stat_i.dth_zero) begin
          state_d = ST_ROT_START;
          sel_d   = MQ_XS;
        end else begin
          state_d = ST_CH_START;
        end
      end
      ST_CH_START:  state_d = ST_CH_WAIT;
      ST_CH_WAIT: begin
        if (stat_i.cordic_done) begin
          state_d = ST_DIV_START;
          sel_d   = MQ_LX;
        end
      end
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (stat_i.div_done) state_d = ST_MQ_LOAD;
      ST_MQ_LOAD:   state_d = ST_MQ_LO;
      ST_MQ_LO:     state_d = ST_MQ_HI;
      ST_MQ_HI:     state_d = ST_MQ_ACC;
      ST_MQ_ACC: begin
        case (sel_q)
          MQ_LX: begin
            sel_d   = MQ_LY;
            state_d = ST_DIV_START;
          end
          MQ_LY: begin
            sel_d   = MQ_XS;
            state_d = ST_ROT_START;
          end
          MQ_XS: begin
            sel_d   = MQ_YC;
            state_d = ST_MQ_LOAD;
          end
          MQ_YC: begin
            sel_d   = MQ_XC;
            state_d = ST_MQ_LOAD;
          end
          MQ_XC: begin
            sel_d   = MQ_YS;
            state_d = ST_MQ_LOAD;
          end
          MQ_YS:   state_d = ST_WRAP;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_ROT_START: state_d = ST_ROT_WAIT;
      ST_ROT_WAIT:  if (stat_i.cordic_done) state_d = ST_MQ_LOAD;
      ST_WRAP:      if (stat_i.wrap_ok) state_d = ST_HEAD;
      ST_HEAD:      state_d = ST_PUB;
      ST_PUB:       if (pub_ok) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.op  = OP_NONE;
    cmd_o.sel = sel_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_DEG:       cmd_o.op = OP_DEG_MUL;
      ST_SETP:      cmd_o.op = OP_SET_POSE;
      ST_ENC:       cmd_o.op = OP_ENC_MUL;
      ST_DIFF:      cmd_o.op = OP_DIFF;
      ST_ZCHK:      if (stat_i.dth_zero) cmd_o.op = OP_COPY_LOCAL;
      ST_CH_START:  cmd_o.op = OP_CORDIC_HALF;
      ST_DIV_START: cmd_o.op = OP_DIV;
      ST_MQ_LOAD:   cmd_o.op = OP_MQ_LOAD;
      ST_MQ_LO:     cmd_o.op = OP_MQ_LO;
      ST_MQ_HI:     cmd_o.op = OP_MQ_HI;
      ST_MQ_ACC:    cmd_o.op = OP_MQ_ACC;
      ST_ROT_START: cmd_o.op = OP_CORDIC_ROT;
      ST_WRAP:      if (!stat_i.wrap_ok) cmd_o.op = OP_WRAP;
      ST_HEAD:      cmd_o.op = OP_HEAD;
      ST_PUB:       if (pub_ok) cmd_o.op = OP_PUBLISH;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (state_q == ST_PUB && pub_ok) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= MQ_LX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/aopt_dp.sv
// ----------------------------------------------------------------------------
// aopt_dp: datapath of the pose tracker
// Pose and sensor history, config registers, one shared multiplier, the CORDIC
// unit and the serial divider, driven by controller commands and config writes.
// ----------------------------------------------------------------------------
`default_nettype none

module aopt_dp
  import aopt_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  input  wire in_req_t     in_req_i,
  output out_req_t         out_req_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  cfg_t     cfg_q;
  in_req_t  in_q;
  out_req_t out_q;

  logic signed [31:0] pos_x_q, pos_y_q, heading_q;
  logic signed [31:0] last_imu_q, last_par_q, last_perp_q;
  logic signed [31:0] rec_q, dth_q, half_q, dx_q, dy_q, lx_q, ly_q;
  logic signed [33:0] nh_q;
  logic signed [66:0] prod_q;
  logic        [61:0] plo_q;
  logic        [59:0] ua_q;
  logic        [31:0] ub_q;
  logic               neg_q;

  logic signed [33:0] mul_a, deg_a;
  logic signed [32:0] mul_b;
  logic signed [31:0] par_v, perp_v, dth_v, half_v;
  logic signed [32:0] half_t;
  logic signed [61:0] mq_a, off_x, off_y;
  logic signed [35:0] mq_b, chord;
  logic        [61:0] mq_a_mag;
  logic        [35:0] mq_b_mag;
  logic        [59:0] mq_r;
  logic        [31:0] mq_res;

  logic               cordic_start, cordic_done;
  logic signed [33:0] cordic_ang, sin_v, cos_v;
  logic               div_done;
  logic signed [60:0] quot;

  // shared multiplier operands
  always_comb begin
    deg_a = in_q.action ? 34'(in_q.new_theta) : -34'(in_q.imu_rotation);
    case (cmd_i.op)
      OP_DEG_MUL: begin
        mul_a = deg_a;
        mul_b = DEG2RAD_K;
      end
      OP_ENC_MUL: begin
        mul_a = 34'(in_q.parallel_travel);
        mul_b = $signed({2'b00, cfg_q.travel_scale});
      end
      OP_MQ_LO: begin
        mul_a = $signed({4'b0000, ua_q[29:0]});
        mul_b = $signed({1'b0, ub_q});
      end
      OP_MQ_HI: begin
        mul_a = $signed({4'b0000, ua_q[59:30]});
        mul_b = $signed({1'b0, ub_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sensor differencing
  always_comb begin
    par_v  = cfg_q.use_drive_encoders ? prod_q[47:16] : in_q.parallel_travel;
    perp_v = cfg_q.use_drive_encoders ? 32'sd0 : in_q.perpendicular_travel;
    dth_v  = rec_q - last_imu_q;
    half_t = 33'(dth_v) + $signed({32'b0, dth_v[31]});
    half_v = half_t[32:1];
  end

  // scaled product operands
  always_comb begin
    chord = 36'(sin_v) <<< 1;
    off_x = cfg_q.use_drive_encoders ? 62'sd0 : 62'(cfg_q.perp_wheel_offset);
    off_y = cfg_q.use_drive_encoders ? -$signed({31'b0, cfg_q.half_track_width})
                                     : 62'(cfg_q.par_wheel_offset);
    case (cmd_i.sel)
      MQ_LX: begin
        mq_a = 62'(quot) + off_x;
        mq_b = chord;
      end
      MQ_LY: begin
        mq_a = 62'(quot) + off_y;
        mq_b = chord;
      end
      MQ_XS: begin
        mq_a = 62'(ly_q);
        mq_b = 36'(sin_v);
      end
      MQ_YC: begin
        mq_a = 62'(ly_q);
        mq_b = -36'(cos_v);
      end
      MQ_XC: begin
        mq_a = 62'(lx_q);
        mq_b = 36'(cos_v);
      end
      MQ_YS: begin
        mq_a = 62'(lx_q);
        mq_b = 36'(sin_v);
      end
      default: begin
        mq_a = '0;
        mq_b = '0;
      end
    endcase
    mq_a_mag = mq_a[61] ? 62'(-mq_a) : 62'(mq_a);
    mq_b_mag = mq_b[35] ? 36'(-mq_b) : 36'(mq_b);
    mq_r     = plo_q[59:0] + {prod_q[29:0], 30'b0};
    mq_res   = neg_q ? 32'(-mq_r[59:28]) : mq_r[59:28];
  end

  assign cordic_start = (cmd_i.op == OP_CORDIC_HALF) || (cmd_i.op == OP_CORDIC_ROT);
  assign cordic_ang   = (cmd_i.op == OP_CORDIC_HALF) ? 34'(half_q)
                                                     : 34'(heading_q) + 34'(half_q);

  aopt_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (cordic_ang),
    .done_o  (cordic_done),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  aopt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.op == OP_DIV),
    .delta_i   ((cmd_i.sel == MQ_LX) ? dx_q : dy_q),
    .divisor_i (dth_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // architectural state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_drive_encoders <= 1'b0;
      cfg_q.par_wheel_offset   <= '0;
      cfg_q.perp_wheel_offset  <= '0;
      cfg_q.half_track_width   <= '0;
      cfg_q.travel_scale       <= SCALE_RESET;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      last_imu_q  <= '0;
      last_par_q  <= '0;
      last_perp_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_USE_ENC:  cfg_q.use_drive_encoders <= cfg_wdata_i[0];
          CFG_PAR_OFF:  cfg_q.par_wheel_offset   <= cfg_wdata_i;
          CFG_PERP_OFF: cfg_q.perp_wheel_offset  <= cfg_wdata_i;
          CFG_HALF_TRK: cfg_q.half_track_width   <= cfg_wdata_i[30:0];
          CFG_SCALE:    cfg_q.travel_scale       <= cfg_wdata_i[30:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_SET_POSE: begin
          pos_x_q   <= in_q.new_x;
          pos_y_q   <= in_q.new_y;
          heading_q <= in_q.theta_is_radians ? in_q.new_theta : prod_q[51:20];
        end
        OP_DIFF: begin
          last_imu_q  <= rec_q;
          last_par_q  <= par_v;
          last_perp_q <= perp_v;
        end
        OP_MQ_ACC: begin
          case (cmd_i.sel)
            MQ_XS, MQ_XC: pos_x_q <= pos_x_q + mq_res;
            MQ_YC, MQ_YS: pos_y_q <= pos_y_q + mq_res;
            default: ;
          endcase
        end
        OP_HEAD: heading_q <= nh_q[31:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_LOAD:    in_q  <= in_req_i;
      OP_ENC_MUL: rec_q <= prod_q[51:20];
      OP_DIFF: begin
        dth_q  <= dth_v;
        half_q <= half_v;
        dx_q   <= par_v - last_par_q;
        dy_q   <= perp_v - last_perp_q;
        nh_q   <= 34'(heading_q) + 34'(dth_v);
      end
      OP_COPY_LOCAL: begin
        lx_q <= dx_q;
        ly_q <= dy_q;
      end
      OP_MQ_LOAD: begin
        ua_q  <= mq_a_mag[59:0];
        ub_q  <= mq_b_mag[31:0];
        neg_q <= mq_a[61] ^ mq_b[35];
      end
      OP_MQ_HI:  plo_q <= prod_q[61:0];
      OP_MQ_ACC: begin
        case (cmd_i.sel)
          MQ_LX:   lx_q <= mq_res;
          MQ_LY:   ly_q <= mq_res;
          default: ;
        endcase
      end
      OP_WRAP: begin
        if (nh_q >= TWO_PI_Q28) nh_q <= nh_q - TWO_PI_Q28;
        else if (nh_q[33]) nh_q <= nh_q + TWO_PI_Q28;
      end
      OP_PUBLISH: begin
        out_q.pose_x       <= pos_x_q;
        out_q.pose_y       <= pos_y_q;
        out_q.pose_heading <= heading_q;
      end
      default: ;
    endcase
  end

  assign stat_o.set_pose    = in_q.action;
  assign stat_o.dth_zero    = (dth_q == '0);
  assign stat_o.cordic_done = cordic_done;
  assign stat_o.div_done    = div_done;
  assign stat_o.wrap_ok     = !nh_q[33] && (nh_q < TWO_PI_Q28);
  assign out_req_o          = out_q;

endmodule

`default_nettype wire

>>> rtl/arc_odometry_pose_tracker.sv
// ----------------------------------------------------------------------------
// arc_odometry_pose_tracker: planar pose from IMU and tracking wheel samples
// Top level: sequencer plus datapath, valid/ready request channels and a
// plain config write port.
// ----------------------------------------------------------------------------
// Each input request either loads the pose (set) or applies one sensor sample
// (update), and always yields one result request carrying x, y (Q16.16) and
// heading (Q4.28 radians). One request is worked on at a time; the next one
// is taken as soon as the result sits in the output register. A set request
// is loaded, passes the degree conversion multiply, then sets the pose and
// publishes the result. An update with no heading change takes one CORDIC run
// and four two-pass scaled multiplies; an update that turns also takes a
// half-angle CORDIC run, the two 60-step serial divides of the arc terms and
// two more scaled multiplies. Either update may take extra CORDIC angle
// reduction steps and heading wrap steps. All products share one 34x33
// multiplier. Config registers (index: 0 encoder mode, 1 parallel offset,
// 2 perpendicular offset, 3 half track width, 4 travel scale) are to be written
// by the user only while idle; the block itself does not enforce this.
`default_nettype none

module arc_odometry_pose_tracker
  import aopt_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_req_t     in_req_i,
  // result request channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_req_t         out_req_o,
  // config writes
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: handshakes and step order
  aopt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: pose state, multiplier, cordic, divider
  aopt_dp #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_req_i    (in_req_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

`default_nettype wire

>>> rtl/aopt_checker.sv
// ----------------------------------------------------------------------------
// aopt_checker: port-level checks of the pose tracker
// Watches both request channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aopt_checker
  import aopt_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire out_req_t out_req_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // a result never appears right after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // a result is published only from a busy cycle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result while idle");

endmodule

bind arc_odometry_pose_tracker aopt_checker u_aopt_checker (.*);

`default_nettype wire
